@@ rtl/gkm_pkg.sv @@
// Shared types, constants and exp tables for the Gaussian kernel block.
package gkm_pkg;

    // Field and datapath widths
    localparam int THETA_W   = 16;
    localparam int SUM_W     = 40;
    localparam int H_W       = 24;
    localparam int KERN_W    = 17;
    localparam int WD_W      = 32;
    localparam int WDSQ_W    = 40;
    localparam int MUL_W     = 25;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 74;
    localparam int W_W       = 33;

    // Default vector length limit
    localparam int MAX_PARAMS_DEF = 64;

    // Queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LVL_W   = $clog2(Q_DEPTH + 1);

    // Fixed-point constants
    localparam logic [H_W-1:0]    CFG_RESET  = 24'h008000;
    localparam logic [25:0]       ONE24      = 26'd16777216;
    localparam logic [25:0]       HALF24     = 26'd8388608;
    localparam logic [63:0]       X_LIMIT    = 64'h0000_1000_0000_0000;
    localparam logic [15:0]       DIV6_RECIP = 16'd43691;
    localparam logic [KERN_W-1:0] KERN_MAX   = 17'd65536;

    // Back-end sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE, ST_X0, ST_X1, ST_X2, ST_X3,
        ST_R2M, ST_R2A, ST_R3M, ST_R3A, ST_D6M, ST_D6A,
        ST_VA, ST_KM, ST_KA,
        ST_W0, ST_W1, ST_W2, ST_W3,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5
    } gkm_state_t;

    // Front to queue: finished vector sum
    typedef struct packed {
        logic             push;
        logic [SUM_W-1:0] sum;
    } gkm_push_t;

    // Queue fill status
    typedef struct packed {
        logic               empty;
        logic [Q_LVL_W-1:0] level;
    } gkm_q_status_t;

    // exp(-i), i = 0..16, Q1.24
    function automatic logic [MUL_W-1:0] exp_int_lut(input logic [4:0] idx);
        logic [MUL_W-1:0] val;
        case (idx)
            5'd0:    val = 25'd16777216;
            5'd1:    val = 25'd6171993;
            5'd2:    val = 25'd2270549;
            5'd3:    val = 25'd835288;
            5'd4:    val = 25'd307285;
            5'd5:    val = 25'd113044;
            5'd6:    val = 25'd41587;
            5'd7:    val = 25'd15299;
            5'd8:    val = 25'd5628;
            5'd9:    val = 25'd2070;
            5'd10:   val = 25'd762;
            5'd11:   val = 25'd280;
            5'd12:   val = 25'd103;
            5'd13:   val = 25'd38;
            5'd14:   val = 25'd14;
            5'd15:   val = 25'd5;
            5'd16:   val = 25'd2;
            default: val = 25'd0;
        endcase
        return val;
    endfunction

    // exp(-j/16), j = 0..15, Q1.24
    function automatic logic [MUL_W-1:0] exp_frac_lut(input logic [3:0] idx);
        logic [MUL_W-1:0] val;
        case (idx)
            4'd0:    val = 25'd16777216;
            4'd1:    val = 25'd15760736;
            4'd2:    val = 25'd14805841;
            4'd3:    val = 25'd13908801;
            4'd4:    val = 25'd13066109;
            4'd5:    val = 25'd12274473;
            4'd6:    val = 25'd11530801;
            4'd7:    val = 25'd10832185;
            4'd8:    val = 25'd10175896;
            4'd9:    val = 25'd9559370;
            4'd10:   val = 25'd8980197;
            4'd11:   val = 25'd8436114;
            4'd12:   val = 25'd7924996;
            4'd13:   val = 25'd7444844;
            4'd14:   val = 25'd6993784;
            4'd15:   val = 25'd6570052;
            default: val = 25'd0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/gkm_if.sv @@
// Handshake channel interfaces: parameter pairs, results, configuration.
interface gkm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [gkm_pkg::THETA_W-1:0]  theta_a;
    logic signed [gkm_pkg::THETA_W-1:0]  theta_b;
    logic                                last_param;

    modport source (output valid, theta_a, theta_b, last_param, input ready);
    modport sink   (input valid, theta_a, theta_b, last_param, output ready);
endinterface

interface gkm_out_if;
    logic                          valid;
    logic                          ready;
    logic [gkm_pkg::KERN_W-1:0]    kernel_value;
    logic [gkm_pkg::WD_W-1:0]      weighted_distance;
    logic [gkm_pkg::WDSQ_W-1:0]    weighted_distance_sq;
    logic                          saturated;

    modport source (output valid, kernel_value, weighted_distance, weighted_distance_sq,
                    saturated, input ready);
    modport sink   (input valid, kernel_value, weighted_distance, weighted_distance_sq,
                    saturated, output ready);
endinterface

interface gkm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [gkm_pkg::H_W-1:0]    half_inv_lambda_sq;

    modport source (output valid, half_inv_lambda_sq, input ready);
    modport sink   (input valid, half_inv_lambda_sq, output ready);
endinterface

@@ rtl/gkm_front.sv @@
// Front end: accepts element pairs, squares differences, accumulates per vector.
module gkm_front #(
    parameter int MAX_PARAMS = gkm_pkg::MAX_PARAMS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    gkm_in_if.sink                 params_in,
    input  gkm_pkg::gkm_q_status_t q_status,
    output gkm_pkg::gkm_push_t     q_push
);
    localparam int CNT_W = $clog2(MAX_PARAMS + 1);

    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        vld_reg;
    logic                        last_reg;
    logic [31:0]                 sq_reg, sq_next;
    logic [gkm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [gkm_pkg::SUM_W:0]     sum_add;
    logic [gkm_pkg::SUM_W-1:0]   sum_sat;
    logic [gkm_pkg::Q_LVL_W:0]   q_need;
    logic                        fire;
    logic                        add_en;
    logic signed [16:0]          diff;
    logic [15:0]                 abs_diff;

    // Room for every vector end already in flight plus this one
    assign q_need = {1'b0, q_status.level} + {{gkm_pkg::Q_LVL_W{1'b0}}, vld_reg & last_reg};
    assign params_in.ready = (q_need < (gkm_pkg::Q_LVL_W+1)'(gkm_pkg::Q_DEPTH));
    assign fire = params_in.valid && params_in.ready;

    // Pairs past the length limit do not add
    assign add_en = (count_reg < CNT_W'(MAX_PARAMS));

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (params_in.last_param)
                count_next = '0;
            else if (add_en)
                count_next = count_reg + CNT_W'(1);
        end
    end

    // Squared difference, stage one
    assign diff     = $signed({params_in.theta_a[15], params_in.theta_a})
                    - $signed({params_in.theta_b[15], params_in.theta_b});
    assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];
    assign sq_next  = add_en ? (32'(abs_diff) * 32'(abs_diff)) : 32'd0;

    // Accumulate, stage two
    assign sum_add = {1'b0, sum_reg} + (gkm_pkg::SUM_W+1)'(sq_reg);
    assign sum_sat = sum_add[gkm_pkg::SUM_W] ? {gkm_pkg::SUM_W{1'b1}}
                                             : sum_add[gkm_pkg::SUM_W-1:0];

    always_comb
    begin
        sum_next    = sum_reg;
        q_push.push = 1'b0;
        q_push.sum  = sum_sat;
        if (vld_reg)
        begin
            if (last_reg)
            begin
                q_push.push = 1'b1;
                sum_next    = '0;
            end
            else
            begin
                sum_next = sum_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            vld_reg   <= 1'b0;
            last_reg  <= 1'b0;
            sum_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            vld_reg   <= fire;
            last_reg  <= params_in.last_param;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

endmodule

@@ rtl/gkm_queue.sv @@
// Short FIFO of finished distance sums between front and back.
module gkm_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gkm_pkg::gkm_push_t          q_push,
    input  logic                        pop,
    output logic [gkm_pkg::SUM_W-1:0]   pop_data,
    output gkm_pkg::gkm_q_status_t      q_status
);
    logic [gkm_pkg::SUM_W-1:0]   slot_reg [gkm_pkg::Q_DEPTH];
    logic [gkm_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gkm_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gkm_pkg::Q_LVL_W-1:0] level_reg, level_next;
    logic                        do_pop;

    localparam logic [gkm_pkg::Q_PTR_W-1:0] LAST_PTR = gkm_pkg::Q_PTR_W'(gkm_pkg::Q_DEPTH - 1);

    assign q_status.empty = (level_reg == '0);
    assign q_status.level = level_reg;
    assign do_pop   = pop && !q_status.empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer wrap and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (q_push.push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + gkm_pkg::Q_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + gkm_pkg::Q_PTR_W'(1);
        if (q_push.push && !do_pop)
            level_next = level_reg + gkm_pkg::Q_LVL_W'(1);
        else if (!q_push.push && do_pop)
            level_next = level_reg - gkm_pkg::Q_LVL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
            slot_reg[wr_ptr_reg] <= q_push.sum;
    end

endmodule

@@ rtl/gkm_back.sv @@
// Back end: sequencer over one shared 25x25 multiplier for exp and moments.
module gkm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gkm_pkg::H_W-1:0]     half_inv_lambda_sq,
    input  gkm_pkg::gkm_q_status_t      q_status,
    input  logic [gkm_pkg::SUM_W-1:0]   pop_data,
    output logic                        pop,
    gkm_out_if.source                   result_out
);
    localparam int MW = gkm_pkg::MUL_W;
    localparam int PW = gkm_pkg::PROD_W;
    localparam int AW = gkm_pkg::ACC_W;

    gkm_pkg::gkm_state_t state_reg, state_next;

    logic [gkm_pkg::SUM_W-1:0]  s_reg, s_next;
    logic [PW-1:0]              p_reg, p_next;
    logic [AW-1:0]              acc_reg, acc_next;
    logic                       over_reg, over_next;
    logic [4:0]                 ip_reg, ip_next;
    logic [3:0]                 jp_reg, jp_next;
    logic [19:0]                r_reg, r_next;
    logic [15:0]                r2_reg, r2_next;
    logic [11:0]                r3_reg, r3_next;
    logic [MW-1:0]              poly_reg, poly_next;
    logic [MW-1:0]              v_reg, v_next;
    logic [gkm_pkg::KERN_W-1:0] kern_reg, kern_next;
    logic [gkm_pkg::W_W-1:0]    w_reg, w_next;
    logic [MW-1:0]              mul_a, mul_b;

    logic                         ov_reg, ov_next;
    logic [gkm_pkg::KERN_W-1:0]   ok_reg, ok_next;
    logic [gkm_pkg::WD_W-1:0]     owd_reg, owd_next;
    logic [gkm_pkg::WDSQ_W-1:0]   owdsq_reg, owdsq_next;
    logic                         osat_reg, osat_next;
    logic                         can_load;

    // Scratch values inside the step logic
    logic [64:0]  x_round;
    logic [48:0]  xq;
    logic [25:0]  poly_full;
    logic [50:0]  rnd_sum;
    logic [25:0]  kern_round;
    logic         wdsq_hi;

    assign can_load = !ov_reg || result_out.ready;

    // Shared multiplier
    assign p_next = PW'(mul_a) * PW'(mul_b);

    // Step order
    always_comb
    begin
        case (state_reg)
            gkm_pkg::ST_IDLE: state_next = q_status.empty ? gkm_pkg::ST_IDLE : gkm_pkg::ST_X0;
            gkm_pkg::ST_X0:   state_next = gkm_pkg::ST_X1;
            gkm_pkg::ST_X1:   state_next = gkm_pkg::ST_X2;
            gkm_pkg::ST_X2:   state_next = gkm_pkg::ST_X3;
            gkm_pkg::ST_X3:   state_next = gkm_pkg::ST_R2M;
            gkm_pkg::ST_R2M:  state_next = gkm_pkg::ST_R2A;
            gkm_pkg::ST_R2A:  state_next = gkm_pkg::ST_R3M;
            gkm_pkg::ST_R3M:  state_next = gkm_pkg::ST_R3A;
            gkm_pkg::ST_R3A:  state_next = gkm_pkg::ST_D6M;
            gkm_pkg::ST_D6M:  state_next = gkm_pkg::ST_D6A;
            gkm_pkg::ST_D6A:  state_next = gkm_pkg::ST_VA;
            gkm_pkg::ST_VA:   state_next = gkm_pkg::ST_KM;
            gkm_pkg::ST_KM:   state_next = gkm_pkg::ST_KA;
            gkm_pkg::ST_KA:   state_next = gkm_pkg::ST_W0;
            gkm_pkg::ST_W0:   state_next = gkm_pkg::ST_W1;
            gkm_pkg::ST_W1:   state_next = gkm_pkg::ST_W2;
            gkm_pkg::ST_W2:   state_next = gkm_pkg::ST_W3;
            gkm_pkg::ST_W3:   state_next = gkm_pkg::ST_Q0;
            gkm_pkg::ST_Q0:   state_next = gkm_pkg::ST_Q1;
            gkm_pkg::ST_Q1:   state_next = gkm_pkg::ST_Q2;
            gkm_pkg::ST_Q2:   state_next = gkm_pkg::ST_Q3;
            gkm_pkg::ST_Q3:   state_next = gkm_pkg::ST_Q4;
            gkm_pkg::ST_Q4:   state_next = gkm_pkg::ST_Q5;
            gkm_pkg::ST_Q5:   state_next = can_load ? gkm_pkg::ST_IDLE : gkm_pkg::ST_Q5;
            default:          state_next = gkm_pkg::ST_IDLE;
        endcase
    end

    // Per-step operand select and datapath updates
    always_comb
    begin
        pop        = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        s_next     = s_reg;
        acc_next   = acc_reg;
        over_next  = over_reg;
        ip_next    = ip_reg;
        jp_next    = jp_reg;
        r_next     = r_reg;
        r2_next    = r2_reg;
        r3_next    = r3_reg;
        poly_next  = poly_reg;
        v_next     = v_reg;
        kern_next  = kern_reg;
        w_next     = w_reg;
        ov_next    = ov_reg && !result_out.ready;
        ok_next    = ok_reg;
        owd_next   = owd_reg;
        owdsq_next = owdsq_reg;
        osat_next  = osat_reg;
        x_round    = 65'(acc_reg[63:0]) + 65'd32768;
        xq         = x_round[64:16];
        poly_full  = gkm_pkg::ONE24 - 26'(r_reg) + 26'(r2_reg[15:1]) - 26'(p_reg[29:18]);
        rnd_sum    = 51'(p_reg) + 51'(gkm_pkg::HALF24);
        kern_round = 26'(rnd_sum[48:24]) + 26'd128;
        wdsq_hi    = |acc_reg[AW-1:64];

        case (state_reg)
            gkm_pkg::ST_IDLE:
            begin
                pop    = !q_status.empty;
                s_next = pop_data;
            end
            // x = s * h in two halves of s
            gkm_pkg::ST_X0:
            begin
                mul_a = MW'(s_reg[19:0]);
                mul_b = MW'(half_inv_lambda_sq);
            end
            gkm_pkg::ST_X1:
            begin
                mul_a    = MW'(s_reg[39:20]);
                mul_b    = MW'(half_inv_lambda_sq);
                acc_next = AW'(p_reg);
            end
            gkm_pkg::ST_X2:
            begin
                acc_next = acc_reg + (AW'(p_reg) << 20);
            end
            // Range reduction: integer, sixteenths, remainder
            gkm_pkg::ST_X3:
            begin
                over_next = (acc_reg[63:0] > gkm_pkg::X_LIMIT) || wdsq_hi;
                ip_next   = xq[28:24];
                jp_next   = xq[23:20];
                r_next    = xq[19:0];
            end
            gkm_pkg::ST_R2M:
            begin
                mul_a = MW'(r_reg);
                mul_b = MW'(r_reg);
            end
            gkm_pkg::ST_R2A:
            begin
                r2_next = p_reg[39:24];
            end
            gkm_pkg::ST_R3M:
            begin
                mul_a = MW'(r2_reg);
                mul_b = MW'(r_reg);
            end
            gkm_pkg::ST_R3A:
            begin
                r3_next = p_reg[35:24];
            end
            // r3 / 6 by reciprocal, exact for r3 below 4096
            gkm_pkg::ST_D6M:
            begin
                mul_a = MW'(r3_reg);
                mul_b = MW'(gkm_pkg::DIV6_RECIP);
            end
            gkm_pkg::ST_D6A:
            begin
                poly_next = poly_full[MW-1:0];
                mul_a     = gkm_pkg::exp_int_lut(ip_reg);
                mul_b     = gkm_pkg::exp_frac_lut(jp_reg);
            end
            gkm_pkg::ST_VA:
            begin
                v_next = rnd_sum[48:24];
            end
            gkm_pkg::ST_KM:
            begin
                mul_a = v_reg;
                mul_b = poly_reg;
            end
            // Q.24 to Q1.16, zero above the argument limit
            gkm_pkg::ST_KA:
            begin
                if (over_reg)
                    kern_next = '0;
                else if (kern_round[25:8] > 18'(gkm_pkg::KERN_MAX))
                    kern_next = gkm_pkg::KERN_MAX;
                else
                    kern_next = kern_round[24:8];
            end
            // w = round(k * s)
            gkm_pkg::ST_W0:
            begin
                mul_a = MW'(kern_reg);
                mul_b = MW'(s_reg[19:0]);
            end
            gkm_pkg::ST_W1:
            begin
                mul_a    = MW'(kern_reg);
                mul_b    = MW'(s_reg[39:20]);
                acc_next = AW'(p_reg) + AW'(gkm_pkg::HALF24);
            end
            gkm_pkg::ST_W2:
            begin
                acc_next = acc_reg + (AW'(p_reg) << 20);
            end
            gkm_pkg::ST_W3:
            begin
                w_next = acc_reg[56:24];
            end
            // w * s over four partial products
            gkm_pkg::ST_Q0:
            begin
                mul_a = w_reg[24:0];
                mul_b = MW'(s_reg[19:0]);
            end
            gkm_pkg::ST_Q1:
            begin
                mul_a    = w_reg[24:0];
                mul_b    = MW'(s_reg[39:20]);
                acc_next = AW'(p_reg) + AW'(gkm_pkg::HALF24);
            end
            gkm_pkg::ST_Q2:
            begin
                mul_a    = MW'(w_reg[32:25]);
                mul_b    = MW'(s_reg[19:0]);
                acc_next = acc_reg + (AW'(p_reg) << 20);
            end
            gkm_pkg::ST_Q3:
            begin
                mul_a    = MW'(w_reg[32:25]);
                mul_b    = MW'(s_reg[39:20]);
                acc_next = acc_reg + (AW'(p_reg) << 25);
            end
            gkm_pkg::ST_Q4:
            begin
                acc_next = acc_reg + (AW'(p_reg) << 45);
            end
            // Clip and load the output register
            gkm_pkg::ST_Q5:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    ok_next    = kern_reg;
                    owd_next   = w_reg[32] ? {gkm_pkg::WD_W{1'b1}} : w_reg[31:0];
                    owdsq_next = wdsq_hi ? {gkm_pkg::WDSQ_W{1'b1}} : acc_reg[63:24];
                    osat_next  = w_reg[32] | wdsq_hi;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign result_out.valid                = ov_reg;
    assign result_out.kernel_value         = ok_reg;
    assign result_out.weighted_distance    = owd_reg;
    assign result_out.weighted_distance_sq = owdsq_reg;
    assign result_out.saturated            = osat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gkm_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        over_reg  <= over_next;
        ip_reg    <= ip_next;
        jp_reg    <= jp_next;
        r_reg     <= r_next;
        r2_reg    <= r2_next;
        r3_reg    <= r3_next;
        poly_reg  <= poly_next;
        v_reg     <= v_next;
        kern_reg  <= kern_next;
        w_reg     <= w_next;
        ok_reg    <= ok_next;
        owd_reg   <= owd_next;
        owdsq_reg <= owdsq_next;
        osat_reg  <= osat_next;
    end

endmodule

@@ rtl/gaussian_kernel_with_moments.sv @@
// Top level: squared-exponential kernel with first and second distance moments.
//
//  Channel    | Dir | Payload                                                  | Request
//  -----------+-----+----------------------------------------------------------+------------------
//  params_in  | in  | theta_a, theta_b, last_param                             | one element pair
//  result_out | out | kernel_value, weighted_distance, weighted_distance_sq,   | one vector result
//             |     | saturated                                                |
//  cfg        | in  | half_inv_lambda_sq                                       | register write
//
//  Element pairs are taken one per cycle; the front squares and accumulates in two stages.
//  Each vector end passes through a two-entry queue to the back sequencer, which finishes
//  one vector before popping the next, on one shared 25x25 multiplier (exp, then k*s and k*s*s).
//  params_in stalls when two vector ends, queued or still in the accumulate stage, wait.
//  A result waits in the output register; the back holds its last step while it is full.
//  Reset (rst_n low, asynchronous) clears sum, counters, queue, sequencer; register to 0.5.
module gaussian_kernel_with_moments #(
    parameter int MAX_PARAMS = gkm_pkg::MAX_PARAMS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gkm_in_if.sink     params_in,
    gkm_out_if.source  result_out,
    gkm_cfg_if.sink    cfg
);
    logic [gkm_pkg::H_W-1:0]    h_reg, h_next;
    gkm_pkg::gkm_push_t         q_push;
    gkm_pkg::gkm_q_status_t     q_status;
    logic [gkm_pkg::SUM_W-1:0]  pop_data;
    logic                       pop;

    // Configuration register, always writable
    assign cfg.ready = 1'b1;
    assign h_next    = cfg.valid ? cfg.half_inv_lambda_sq : h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_reg <= gkm_pkg::CFG_RESET;
        else
            h_reg <= h_next;
    end

    gkm_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .params_in (params_in),
        .q_status  (q_status),
        .q_push    (q_push)
    );

    gkm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .pop_data (pop_data),
        .q_status (q_status)
    );

    gkm_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .half_inv_lambda_sq (h_reg),
        .q_status           (q_status),
        .pop_data           (pop_data),
        .pop                (pop),
        .result_out         (result_out)
    );

endmodule

@@ rtl/gkm_checker.sv @@
// Port-level checker for the result channel, bound to the top level.
module gkm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [gkm_pkg::KERN_W-1:0]   kernel_value,
    input logic [gkm_pkg::WD_W-1:0]     weighted_distance,
    input logic [gkm_pkg::WDSQ_W-1:0]   weighted_distance_sq,
    input logic                         saturated
);
    // Kernel never exceeds one
    a_kern_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kernel_value <= gkm_pkg::KERN_MAX))
    else $error("kernel_value above 1.0");

    // A clipped result shows a clipped field
    a_sat_field: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            ((weighted_distance == {gkm_pkg::WD_W{1'b1}}) ||
             (weighted_distance_sq == {gkm_pkg::WDSQ_W{1'b1}})))
    else $error("saturated without a clipped output");

    // Zero kernel gives zero moments and no clipping
    a_zero_kern: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kernel_value == '0)) |->
            ((weighted_distance == '0) && (weighted_distance_sq == '0) && !saturated))
    else $error("nonzero moments with zero kernel");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(kernel_value) && $stable(weighted_distance) &&
             $stable(weighted_distance_sq) && $stable(saturated)))
    else $error("result changed while stalled");

endmodule

bind gaussian_kernel_with_moments gkm_checker u_gkm_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .out_valid            (result_out.valid),
    .out_ready            (result_out.ready),
    .kernel_value         (result_out.kernel_value),
    .weighted_distance    (result_out.weighted_distance),
    .weighted_distance_sq (result_out.weighted_distance_sq),
    .saturated            (result_out.saturated)
);

@@ test/tb_top.sv @@
// Testbench for gaussian_kernel_with_moments: random element-pair vectors with a scoreboard.
module tb_top;
    import gkm_pkg::*;

    // Expected or observed result of one vector
    typedef struct packed {
        logic [KERN_W-1:0] kern;
        logic [WD_W-1:0]   wd;
        logic [WDSQ_W-1:0] wdsq;
        logic              sat;
    } kernel_moments_t;

    localparam bit [63:0] Q24_ONE     = 64'd1 << 24;
    localparam bit [63:0] Q24_HALF    = 64'd1 << 23;
    localparam bit [63:0] SUM_CEIL    = 64'hFF_FFFF_FFFF;
    localparam bit [63:0] WD_CEIL     = 64'hFFFF_FFFF;
    localparam bit [63:0] WDSQ_CEIL   = 64'hFF_FFFF_FFFF;
    localparam bit [63:0] ARG_LIMIT   = 64'd16 << 40;
    localparam int        VECTOR_CAP  = MAX_PARAMS_DEF;
    localparam int        DRAIN_CYCLES = 40;
    localparam int        HOLD_CYCLES  = 300;
    localparam int        PHASE_COUNT  = 7;
    localparam int        PHASE_PAIRS  = 160;

    // exp(-i), i = 0..16, and exp(-j/16), j = 0..15, both Q1.24
    localparam bit [24:0] EXP_WHOLE [0:16] = '{
        25'd16777216, 25'd6171993, 25'd2270549, 25'd835288, 25'd307285, 25'd113044,
        25'd41587, 25'd15299, 25'd5628, 25'd2070, 25'd762, 25'd280, 25'd103, 25'd38,
        25'd14, 25'd5, 25'd2
    };
    localparam bit [24:0] EXP_SIXTEENTH [0:15] = '{
        25'd16777216, 25'd15760736, 25'd14805841, 25'd13908801, 25'd13066109,
        25'd12274473, 25'd11530801, 25'd10832185, 25'd10175896, 25'd9559370,
        25'd8980197, 25'd8436114, 25'd7924996, 25'd7444844, 25'd6993784, 25'd6570052
    };

    // Distance accumulator, kernel prediction and result comparison
    class kernel_scoreboard;
        bit [H_W-1:0]    scale;
        bit [63:0]       dist_sum;
        int unsigned     pair_count;
        kernel_moments_t moments_q[$];
        int unsigned     errors;

        function new();
            scale      = CFG_RESET;
            dist_sum   = 0;
            pair_count = 0;
            errors     = 0;
        endfunction

        function void set_scale(bit [H_W-1:0] value);
            scale = value;
        endfunction

        function int unsigned pending();
            return moments_q.size();
        endfunction

        function bit [63:0] round24(bit [63:0] p);
            return (p + Q24_HALF) >> 24;
        endfunction

        // exp(-x), x in Q.24 up to 16.0: whole and sixteenth tables, cubic for the rest
        function bit [63:0] exp_neg_q24(bit [63:0] xq);
            bit [63:0] whole, frac, r, r2, r3, poly;
            whole = (xq >> 24) & 64'd31;
            frac  = (xq >> 20) & 64'd15;
            r     = xq & 64'hF_FFFF;
            if (whole > 16)
                return 0;
            r2   = (r * r) >> 24;
            r3   = (r2 * r) >> 24;
            poly = Q24_ONE - r + (r2 >> 1) - r3 / 6;
            return round24(round24(64'(EXP_WHOLE[int'(whole)]) *
                                   64'(EXP_SIXTEENTH[int'(frac)])) * poly);
        endfunction

        function kernel_moments_t kernel_moments(bit [63:0] s);
            kernel_moments_t m;
            bit [63:0]       x, xq, k, wd_full;
            bit [127:0]      wdsq_full;
            m = '0;
            x = s * 64'(scale);
            // argument above 16 leaves everything at zero
            if (x <= ARG_LIMIT) begin
                xq = (x + (64'd1 << 15)) >> 16;
                k  = (exp_neg_q24(xq) + 64'd128) >> 8;
                if (k > 64'(KERN_MAX))
                    k = 64'(KERN_MAX);
                wd_full   = round24(k * s);
                wdsq_full = (128'(wd_full) * 128'(s) + 128'(Q24_HALF)) >> 24;
                m.kern = k[KERN_W-1:0];
                if (wd_full > WD_CEIL) begin
                    m.wd  = '1;
                    m.sat = 1'b1;
                end
                else
                    m.wd = wd_full[WD_W-1:0];
                if (wdsq_full > 128'(WDSQ_CEIL)) begin
                    m.wdsq = '1;
                    m.sat  = 1'b1;
                end
                else
                    m.wdsq = wdsq_full[WDSQ_W-1:0];
            end
            return m;
        endfunction

        // Accepted element pair: accumulate, and on the last mark queue the result
        function void note_pair(logic signed [THETA_W-1:0] a, logic signed [THETA_W-1:0] b,
                                logic last);
            int        diff;
            bit [63:0] mag;
            // pairs beyond the vector cap do not count toward the sum
            if (pair_count < VECTOR_CAP) begin
                diff = int'(a) - int'(b);
                mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
                dist_sum = (dist_sum + mag * mag > SUM_CEIL) ? SUM_CEIL : dist_sum + mag * mag;
                pair_count++;
            end
            if (last) begin
                moments_q.push_back(kernel_moments(dist_sum));
                dist_sum   = 0;
                pair_count = 0;
            end
        endfunction

        function void check_result(kernel_moments_t got);
            kernel_moments_t want;
            if (moments_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kern=%0d wd=%0d wdsq=%0d sat=%0b",
                             got.kern, got.wd, got.wdsq, got.sat);
                return;
            end
            want = moments_q.pop_front();
            if (got.kern !== want.kern || got.wd !== want.wd ||
                got.wdsq !== want.wdsq || got.sat !== want.sat) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: exp kern=%0d wd=%0d wdsq=%0d sat=%0b, got kern=%0d wd=%0d wdsq=%0d sat=%0b",
                             want.kern, want.wd, want.wdsq, want.sat,
                             got.kern, got.wd, got.wdsq, got.sat);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_idle;
    bit   rx_idle;
    bit   hold_request;

    kernel_scoreboard sb;

    gkm_in_if  params_in_if ();
    gkm_out_if result_if ();
    gkm_cfg_if cfg_if ();

    gaussian_kernel_with_moments DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .params_in  (params_in_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Observe handshakes on both channels
    always @(posedge clk) begin
        if (rst_n) begin
            if (params_in_if.valid && params_in_if.ready)
                sb.note_pair(params_in_if.theta_a, params_in_if.theta_b,
                             params_in_if.last_param);
            if (result_if.valid && result_if.ready)
                sb.check_result(kernel_moments_t'({result_if.kernel_value,
                                                   result_if.weighted_distance,
                                                   result_if.weighted_distance_sq,
                                                   result_if.saturated}));
        end
    end

    // Result side: random ready gaps, one long hold-off on request
    initial begin
        int gap;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            if (hold_request) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
        end
    end

    // One element-pair request; returns at the edge where it is taken
    task automatic send_pair(input logic [THETA_W-1:0] a, input logic [THETA_W-1:0] b,
                             input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            params_in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        params_in_if.valid      <= 1'b1;
        params_in_if.theta_a    <= a;
        params_in_if.theta_b    <= b;
        params_in_if.last_param <= last;
        @(posedge clk);
        while (!params_in_if.ready)
            @(posedge clk);
    endtask

    function automatic logic [THETA_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // One vector of random length and content
    task automatic send_random_vector(output int len);
        int                 pick, mode, width;
        logic [THETA_W-1:0] a, b;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(60, 72);
        mode = $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
            if (mode < 5) begin
                // close pairs keep the kernel away from zero
                width = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 9);
                a = 16'($urandom);
                b = a ^ 16'($urandom & ((32'd1 << width) - 1));
            end
            else if (mode < 8) begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            else begin
                a = corner_value();
                b = corner_value();
            end
            send_pair(a, b, i == len - 1);
        end
    endtask

    // Stop sending and wait until every queued result has come out
    task automatic drain();
        params_in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [H_W-1:0] value);
        cfg_if.valid              <= 1'b1;
        cfg_if.half_inv_lambda_sq <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        sb.set_scale(value);
    endtask

    // Main sequence
    initial begin
        int           len;
        int           sent;
        bit           paused;
        logic [H_W-1:0] scale;
        sb = new();
        rst_n                     <= 1'b0;
        params_in_if.valid        <= 1'b0;
        params_in_if.theta_a      <= '0;
        params_in_if.theta_b      <= '0;
        params_in_if.last_param   <= 1'b0;
        cfg_if.valid              <= 1'b0;
        cfg_if.half_inv_lambda_sq <= '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_request = 1'b0;
        paused       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed vectors at the reset scale of 0.5
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);     // largest distance, argument above 16
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h7FFF, 16'h7FFF, 1'b1);
        send_pair(16'h4000, 16'h0000, 1'b0);     // argument exactly 16
        send_pair(16'h0000, 16'hC000, 1'b1);
        send_pair(16'h0800, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'h0001, 1'b1);
        drain();

        // Zero scale with a long wide vector: kernel is one, second moment clips
        write_scale('0);
        for (int i = 0; i < 17; i++)
            send_pair(16'h7FFF, 16'h8000, i == 16);
        drain();

        // Random phases, one scale setting each
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       scale = 24'hFFFFFF;
                1:       scale = 24'h000001;
                2:       scale = 24'h010000;
                3:       scale = 24'($urandom);
                4:       scale = 24'h000100;
                5:       scale = 24'($urandom_range(0, 32'hFFFF));
                default: scale = CFG_RESET;
            endcase
            write_scale(scale);
            if (p == 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
            end
            if (p == 2)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_PAIRS) begin
                send_random_vector(len);
                sent += len;
                if (p == 3 && !paused && sent >= PHASE_PAIRS / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gkm_pkg.sv
rtl/gkm_if.sv
rtl/gkm_front.sv
rtl/gkm_queue.sv
rtl/gkm_back.sv
rtl/gaussian_kernel_with_moments.sv
rtl/gkm_checker.sv
test/tb_top.sv
